[rtl/cable_winch_motor_step_assert.svh]
// ----------------------------------------------------------------------------
// Cable winch motor step: assertion macros
// Concurrent checks used by the cable winch motor step top module.
// ----------------------------------------------------------------------------
`ifndef CABLE_WINCH_MOTOR_STEP_ASSERT_SVH
`define CABLE_WINCH_MOTOR_STEP_ASSERT_SVH

// Same-cycle implication.
`define CWMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CWMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cwms_pkg.sv]
// ----------------------------------------------------------------------------
// Cable winch motor step: package
// Payload types, micro-op codes and the control store of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cwms_pkg;

    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] UPC_CEILING  = 5'd6;
    localparam logic [UPC_W-1:0] UPC_TEN_MUL  = 5'd5;
    localparam logic [UPC_W-1:0] UPC_START    = 5'd0;
    localparam logic [UPC_W-1:0] UPC_LAST     = 5'd22;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic [1:0] REQ_TORQUE  = 2'd0;
    localparam logic [1:0] REQ_LENGTH  = 2'd1;
    localparam logic [1:0] REQ_TENSION = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    localparam logic [3:0] CFG_RADIUS    = 4'd0;
    localparam logic [3:0] CFG_FRICTION  = 4'd1;
    localparam logic [3:0] CFG_INV_INER  = 4'd2;
    localparam logic [3:0] CFG_BACKDRIVE = 4'd3;
    localparam logic [3:0] CFG_MAX_TEN   = 4'd4;
    localparam logic [3:0] CFG_INV_FREE  = 4'd5;
    localparam logic [3:0] CFG_MIN_REST  = 4'd6;
    localparam logic [3:0] CFG_GAIN      = 4'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] command_value;
        logic [30:0]        measured_tension;
        logic [30:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic [30:0]        rest_length;
        logic signed [31:0] motor_speed;
        logic signed [31:0] cable_speed;
        logic signed [31:0] applied_torque;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    typedef enum logic [3:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_SUBP,
        UOP_ABS,
        UOP_MUL,
        UOP_MULP,
        UOP_LIM,
        UOP_VEL,
        UOP_CLMP,
        UOP_OUT
    } t_uop;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_CMD,
        SRC_TEN,
        SRC_DT,
        SRC_V,
        SRC_REST,
        SRC_RAD,
        SRC_FRIC,
        SRC_IINV,
        SRC_MAXT,
        SRC_IFS,
        SRC_GAIN,
        SRC_T0,
        SRC_T1,
        SRC_T2
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_T0,
        DST_T1,
        DST_T2,
        DST_V,
        DST_REST
    } t_dst;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_MODE0,
        COND_MODE2,
        COND_MODE3
    } t_cond;

    typedef struct packed {
        t_uop             op;
        t_src             src_a;
        t_src             src_b;
        t_src             src_c;
        t_dst             dst;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             last;
    } t_uword;

    function automatic t_uword f_uw(input t_uop op, input t_src a, input t_src b,
                                    input t_src c, input t_dst d, input t_cond cd,
                                    input logic [UPC_W-1:0] tgt, input logic last);
        t_uword w;
        w.op     = op;
        w.src_a  = a;
        w.src_b  = b;
        w.src_c  = c;
        w.dst    = d;
        w.cond   = cd;
        w.target = tgt;
        w.last   = last;
        return w;
    endfunction

    // Desired torque, speed ceiling, limit, acceleration, Euler update, outputs.
    function automatic t_uword f_urom(input logic [UPC_W-1:0] addr);
        t_uword w;
        case (addr)
            5'd0:  w = f_uw(UOP_ADD,  SRC_CMD,  SRC_ZERO, SRC_ZERO, DST_T0,   COND_MODE0,
                            UPC_CEILING, 1'b0);
            5'd1:  w = f_uw(UOP_ADD,  SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_T0,   COND_MODE3,
                            UPC_CEILING, 1'b0);
            5'd2:  w = f_uw(UOP_SUB,  SRC_CMD,  SRC_TEN,  SRC_ZERO, DST_T0,   COND_MODE2,
                            UPC_TEN_MUL, 1'b0);
            5'd3:  w = f_uw(UOP_SUBP, SRC_CMD,  SRC_REST, SRC_ZERO, DST_T0,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd4:  w = f_uw(UOP_MUL,  SRC_GAIN, SRC_T0,   SRC_ZERO, DST_T0,   COND_ALWAYS,
                            UPC_CEILING, 1'b0);
            5'd5:  w = f_uw(UOP_MUL,  SRC_T0,   SRC_RAD,  SRC_ZERO, DST_T0,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd6:  w = f_uw(UOP_ABS,  SRC_V,    SRC_ZERO, SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd7:  w = f_uw(UOP_MUL,  SRC_RAD,  SRC_T1,   SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd8:  w = f_uw(UOP_MUL,  SRC_T1,   SRC_IFS,  SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd9:  w = f_uw(UOP_SUB,  SRC_ONE,  SRC_T1,   SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd10: w = f_uw(UOP_MUL,  SRC_MAXT, SRC_RAD,  SRC_ZERO, DST_T2,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd11: w = f_uw(UOP_MULP, SRC_T2,   SRC_T1,   SRC_ZERO, DST_T2,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd12: w = f_uw(UOP_LIM,  SRC_T0,   SRC_T2,   SRC_ZERO, DST_T0,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd13: w = f_uw(UOP_MUL,  SRC_FRIC, SRC_V,    SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd14: w = f_uw(UOP_MUL,  SRC_TEN,  SRC_RAD,  SRC_ZERO, DST_T2,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd15: w = f_uw(UOP_SUB,  SRC_T0,   SRC_T1,   SRC_T2,   DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd16: w = f_uw(UOP_MUL,  SRC_T1,   SRC_IINV, SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd17: w = f_uw(UOP_MUL,  SRC_T1,   SRC_DT,   SRC_ZERO, DST_T2,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd18: w = f_uw(UOP_VEL,  SRC_V,    SRC_T2,   SRC_ZERO, DST_V,    COND_NEVER,
                            UPC_START, 1'b0);
            5'd19: w = f_uw(UOP_MUL,  SRC_V,    SRC_DT,   SRC_ZERO, DST_T2,   COND_NEVER,
                            UPC_START, 1'b0);
            5'd20: w = f_uw(UOP_CLMP, SRC_REST, SRC_T2,   SRC_ZERO, DST_REST, COND_NEVER,
                            UPC_START, 1'b0);
            5'd21: w = f_uw(UOP_MUL,  SRC_V,    SRC_RAD,  SRC_ZERO, DST_T1,   COND_NEVER,
                            UPC_START, 1'b0);
            default: w = f_uw(UOP_OUT, SRC_ZERO, SRC_ZERO, SRC_ZERO, DST_NONE, COND_NEVER,
                              UPC_START, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/cwms_exec.sv]
// ----------------------------------------------------------------------------
// Cable winch motor step: execution unit
// Q16.16 multiply, saturating add, absolute value, limit, block and clamp operations.
// ----------------------------------------------------------------------------
`default_nettype none

module cwms_exec (
    input  cwms_pkg::t_uop     i_op,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [31:0] i_c,
    input  logic signed [31:0] i_acc,
    input  logic signed [31:0] i_applied,
    input  logic               i_backdrivable,
    input  logic [30:0]        i_min_rest,
    output logic signed [31:0] o_result
);
    import cwms_pkg::*;

    function automatic logic signed [31:0] f_sat48(input logic [47:0] x);
        logic signed [31:0] r;
        if ((x[47:31] == '0) || (x[47:31] == '1)) begin
            r = x[31:0];
        end else if (x[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    logic signed [63:0] prod;
    logic signed [31:0] qm;
    logic [33:0]        b_ext;
    logic [33:0]        sum;
    logic signed [31:0] sum_sat;
    logic signed [32:0] abs_a;
    logic signed [32:0] b_33;
    logic [32:0]        tgt;
    logic [32:0]        diff;
    logic               block;

    assign prod    = i_a * i_b;
    assign qm      = f_sat48(prod[63:16]);

    assign b_ext   = {{2{i_b[31]}}, i_b};
    assign sum     = {{2{i_a[31]}}, i_a} + ((i_op == UOP_SUB) ? (~b_ext + 34'd1) : b_ext)
                     + {{2{i_c[31]}}, i_c};
    assign sum_sat = f_sat48({{14{sum[33]}}, sum});

    assign abs_a   = i_a[31] ? (~{i_a[31], i_a} + 33'd1) : {i_a[31], i_a};
    assign b_33    = {i_b[31], i_b};

    assign tgt     = i_a[31] ? 33'd0 : {1'b0, i_a};
    assign diff    = tgt - {i_b[31], i_b};

    assign block   = !i_backdrivable &&
                     (((i_acc <= 32'sd0) && (i_applied >= 32'sd0)) ||
                      ((i_acc >= 32'sd0) && (i_applied <= 32'sd0)));

    always_comb begin
        case (i_op)
            UOP_ADD, UOP_SUB: begin
                o_result = sum_sat;
            end
            UOP_SUBP: begin
                o_result = f_sat48({{15{diff[32]}}, diff});
            end
            UOP_ABS: begin
                o_result = abs_a[31] ? 32'sh7FFF_FFFF : abs_a[31:0];
            end
            UOP_MUL: begin
                o_result = qm;
            end
            UOP_MULP: begin
                o_result = (i_b <= 32'sd0) ? 32'sd0 : qm;
            end
            UOP_LIM: begin
                if (i_b <= 32'sd0) begin
                    o_result = 32'sd0;
                end else if (abs_a < b_33) begin
                    o_result = i_a;
                end else begin
                    o_result = i_a[31] ? -i_b : i_b;
                end
            end
            UOP_VEL: begin
                o_result = (block && (sum_sat > 32'sd0)) ? 32'sd0 : sum_sat;
            end
            UOP_CLMP: begin
                o_result = (sum_sat <= $signed({1'b0, i_min_rest})) ?
                           $signed({1'b0, i_min_rest}) : sum_sat;
            end
            default: begin
                o_result = 32'sd0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/cable_winch_motor_step.sv]
// ----------------------------------------------------------------------------
// Cable winch motor step
// One motor tick per transaction: torque command, speed-dependent limit,
// acceleration and semi-implicit Euler update of velocity and rest length.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+--------------------------
//  in       | to block  | valid / stall     | cwms_pkg::t_in_item
//  out      | from block| valid / stall     | cwms_pkg::t_out_item
//  cfg      | to block  | valid / ready     | index 4 bits, data 32 bits
//
//  A transaction runs 18 to 22 microcode steps (mode dependent) on one shared
//  Q16.16 multiplier, one step per cycle, once the input has been accepted in
//  the idle state. The final step waits while the output register still holds
//  an untaken result. Reset is synchronous; no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cable_winch_motor_step_assert.svh"

module cable_winch_motor_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cwms_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cwms_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [3:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import cwms_pkg::*;

    t_seq_state         r_state, n_state;
    logic [UPC_W-1:0]   r_upc, n_upc;
    t_in_item           r_in;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_t0, r_t1, r_t2, r_v, r_rest;
    logic [30:0]        r_radius, r_friction, r_inv_iner, r_max_ten;
    logic [30:0]        r_inv_free, r_min_rest, r_gain;
    logic               r_backdrivable;

    t_uword             uw;
    logic signed [31:0] op_a, op_b, op_c, ex_result;
    logic               in_acc, jump, step_fire;

    function automatic logic signed [31:0] f_operand(input t_src s);
        logic signed [31:0] r;
        case (s)
            SRC_ZERO: r = 32'sd0;
            SRC_ONE:  r = Q_ONE;
            SRC_CMD:  r = r_in.command_value;
            SRC_TEN:  r = {1'b0, r_in.measured_tension};
            SRC_DT:   r = {1'b0, r_in.time_step};
            SRC_V:    r = r_v;
            SRC_REST: r = r_rest;
            SRC_RAD:  r = {1'b0, r_radius};
            SRC_FRIC: r = {1'b0, r_friction};
            SRC_IINV: r = {1'b0, r_inv_iner};
            SRC_MAXT: r = {1'b0, r_max_ten};
            SRC_IFS:  r = {1'b0, r_inv_free};
            SRC_GAIN: r = {1'b0, r_gain};
            SRC_T0:   r = r_t0;
            SRC_T1:   r = r_t1;
            SRC_T2:   r = r_t2;
            default:  r = 32'sd0;
        endcase
        return r;
    endfunction

    assign uw          = f_urom(r_upc);
    assign op_a        = f_operand(uw.src_a);
    assign op_b        = f_operand(uw.src_b);
    assign op_c        = f_operand(uw.src_c);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign step_fire   = (r_state == S_RUN) && !uw.last;

    cwms_exec u_exec (
        .i_op           (uw.op),
        .i_a            (op_a),
        .i_b            (op_b),
        .i_c            (op_c),
        .i_acc          (r_t1),
        .i_applied      (r_t0),
        .i_backdrivable (r_backdrivable),
        .i_min_rest     (r_min_rest),
        .o_result       (ex_result)
    );

    always_comb begin
        case (uw.cond)
            COND_ALWAYS: jump = 1'b1;
            COND_MODE0:  jump = (r_in.req_type == REQ_TORQUE);
            COND_MODE2:  jump = (r_in.req_type == REQ_TENSION);
            COND_MODE3:  jump = (r_in.req_type == REQ_NONE);
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_upc       = r_upc;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                    n_upc   = UPC_START;
                end
            end
            S_RUN: begin
                if (uw.last) begin
                    if (!r_out_valid || !i_out_stall) begin
                        n_out.rest_length    = r_rest[30:0];
                        n_out.motor_speed    = r_v;
                        n_out.cable_speed    = r_t1;
                        n_out.applied_torque = r_t0;
                        n_out_valid          = 1'b1;
                        n_state              = S_IDLE;
                    end
                end else begin
                    n_upc = jump ? uw.target : r_upc + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_upc          <= UPC_START;
            r_out_valid    <= 1'b0;
            r_v            <= 32'sd0;
            r_rest         <= 32'sd0;
            r_radius       <= 31'h0001_0000;
            r_friction     <= 31'd0;
            r_inv_iner     <= 31'h0001_0000;
            r_backdrivable <= 1'b1;
            r_max_ten      <= 31'h0001_0000;
            r_inv_free     <= 31'h0001_0000;
            r_min_rest     <= 31'd0;
            r_gain         <= 31'h0064_0000;
        end else begin
            r_state     <= n_state;
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
            if (step_fire && (uw.dst == DST_V)) begin
                r_v <= ex_result;
            end
            if (step_fire && (uw.dst == DST_REST)) begin
                r_rest <= ex_result;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RADIUS:    r_radius       <= i_cfg_data[30:0];
                    CFG_FRICTION:  r_friction     <= i_cfg_data[30:0];
                    CFG_INV_INER:  r_inv_iner     <= i_cfg_data[30:0];
                    CFG_BACKDRIVE: r_backdrivable <= i_cfg_data[0];
                    CFG_MAX_TEN:   r_max_ten      <= i_cfg_data[30:0];
                    CFG_INV_FREE:  r_inv_free     <= i_cfg_data[30:0];
                    CFG_MIN_REST:  r_min_rest     <= i_cfg_data[30:0];
                    CFG_GAIN:      r_gain         <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (step_fire) begin
            case (uw.dst)
                DST_T0:  r_t0 <= ex_result;
                DST_T1:  r_t1 <= ex_result;
                DST_T2:  r_t2 <= ex_result;
                default: begin
                end
            endcase
        end
    end

    `CWMS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc,
                      (r_state == S_RUN) && (r_upc == UPC_START), "accept did not start")
    `CWMS_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n,
                      (r_state == S_RUN) && uw.last && r_out_valid && i_out_stall,
                      (r_state == S_RUN) && $stable(r_upc), "final step not held")
    `CWMS_ASSERT_NOW(a_out_from_run, i_clk, i_rst_n, $rose(r_out_valid),
                     $past(r_state) == S_RUN, "result without a finished run")
    `CWMS_ASSERT_NOW(a_upc_range, i_clk, i_rst_n, r_state == S_RUN,
                     r_upc <= UPC_LAST, "step counter out of program")

endmodule

`default_nettype wire
